[rtl/sliding_window_arq_controller_unit_defines.svh]
// Assertion macros for the ARQ controller.
`ifndef SLIDING_WINDOW_ARQ_CONTROLLER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_ARQ_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SWAC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);
`define SWAC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWAC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define SWAC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[rtl/swac_pkg.sv]
package swac_pkg;

  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SEQ_W  = 16;

  localparam logic [7:0] MAX_PAYLOAD = 8'd119;
  localparam logic [4:0] PHY_QUEUE   = 5'd16;

  localparam logic [7:0]  TYPE_IDLE  = 8'h00;
  localparam logic [7:0]  TYPE_HELLO = 8'h01;
  localparam logic [7:0]  TYPE_PONG  = 8'h04;

  localparam logic [1:0]  ROLE_MASTER = 2'd1;
  localparam logic [1:0]  ROLE_SLAVE  = 2'd2;

  localparam logic [7:0]  RETRY_INTERVAL_RST = 8'd40;
  localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd12;
  localparam logic [15:0] PREV_RX_SEQ_RST    = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_SENT      = 3'd0,
    KIND_REFUSED   = 3'd1,
    KIND_RETX      = 3'd2,
    KIND_EXHAUSTED = 3'd3,
    KIND_DELIVERED = 3'd4,
    KIND_DUPLICATE = 3'd5,
    KIND_IDLE_RX   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CFG_ROLE_MASTER    = 2'd0,
    CFG_RETRY_INTERVAL = 2'd1,
    CFG_RETRY_LIMIT    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [SEQ_W-1:0]  unacked;
    logic [7:0]        frame_type;
    logic [7:0]        len;
    logic [1:0]        role;
  } result_t;

endpackage

[rtl/sliding_window_arq_controller_unit.sv]
// Sliding-window ARQ header bookkeeping over a 16-bit sequence space with a
// window of 16 slots. Items on the in_ stream are send requests, received
// frame headers and one-millisecond ticks (selected by in_tuser); each send
// or receive yields one result, a tick yields zero to sixteen results, the
// last one marked with out_tlast. One item is worked at a time and in_tready
// is low meanwhile. A send is accepted, then reported. A receive is accepted,
// its acknowledgment is swept over every slot, the oldest-unacked pointer
// walks forward over free slots until it stops, and the result is reported.
// A tick is accepted, each slot is visited in turn and the last result is
// flushed; the scan ends early once a retransmission finds no PHY room left.
// Ordering comparisons of sequence numbers and tick ages run through one
// shared 16-bit subtractor. A result that is not taken stalls further
// reports until out_tready returns.
`include "sliding_window_arq_controller_unit_defines.svh"

module sliding_window_arq_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_type[7:0], ack_req[8], payload_len[16:9], rx_seq[32:17],
  // rx_ack[48:33], phy_space[53:49], zero fill[55:54]
  input  logic [55:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[3:0], seq_out[19:4], ack_out[35:20], unacked_out[51:36],
  // type_out[59:52], len_out[67:60], role_code[69:68], zero fill[71:70]
  output logic [71:0] out_tdata,
  // kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int NW = swac_pkg::WINDOW;
  localparam int SW = swac_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(swac_pkg::WINDOW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_RX_ACK,
    ST_RX_ADV,
    ST_RX_OUT,
    ST_TICK_SCAN,
    ST_TICK_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;

  logic       role_master_r, role_master_nxt;
  logic [7:0] retry_interval_r, retry_interval_nxt;
  logic [7:0] retry_limit_r, retry_limit_nxt;

  logic [15:0] next_tx_seq_r, next_tx_seq_nxt;
  logic [15:0] oldest_unacked_r, oldest_unacked_nxt;
  logic [15:0] expected_rx_seq_r, expected_rx_seq_nxt;
  logic [15:0] previous_rx_seq_r, previous_rx_seq_nxt;
  logic [15:0] now_ms_r, now_ms_nxt;
  logic [NW-1:0] slot_busy_r, slot_busy_nxt;

  logic [7:0]  type_r, type_nxt;
  logic        ack_req_r, ack_req_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] rx_seq_r, rx_seq_nxt;
  logic [15:0] rx_ack_r, rx_ack_nxt;
  logic [4:0]  space_r, space_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  swac_pkg::result_t out_res_r, out_res_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  swac_pkg::result_t hold_res_r, hold_res_nxt;

  logic [15:0] slot_seq_r [NW];
  logic [15:0] slot_seq_nxt [NW];
  logic [7:0]  slot_tries_r [NW];
  logic [7:0]  slot_tries_nxt [NW];
  logic [15:0] slot_time_r [NW];
  logic [15:0] slot_time_nxt [NW];
  logic [7:0]  slot_type_r [NW];
  logic [7:0]  slot_type_nxt [NW];
  logic [7:0]  slot_len_r [NW];
  logic [7:0]  slot_len_nxt [NW];
  logic [15:0] slot_ack_r [NW];
  logic [15:0] slot_ack_nxt [NW];
  logic [15:0] slot_unacked_r [NW];
  logic [15:0] slot_unacked_nxt [NW];

  logic [15:0] sub_a, sub_b, sub_d;
  logic        sub_cin;

  logic [7:0]  in_type, in_len;
  logic        in_ack_req;
  logic [15:0] in_rx_seq, in_rx_ack;
  logic [4:0]  in_space;
  logic        emit_ok;
  logic [1:0]  role_w;

  assign in_type     = in_tdata[7:0];
  assign in_ack_req  = in_tdata[8];
  assign in_len      = in_tdata[16:9];
  assign in_rx_seq   = in_tdata[32:17];
  assign in_rx_ack   = in_tdata[48:33];
  assign in_space    = in_tdata[53:49];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b00, out_res_r.role, out_res_r.len, out_res_r.frame_type,
                       out_res_r.unacked, out_res_r.ack, out_res_r.seq, out_res_r.slot};

  assign emit_ok = !out_valid_r || out_tready;
  assign role_w  = role_master_r ? swac_pkg::ROLE_MASTER : swac_pkg::ROLE_SLAVE;

  // shared subtractor: a - b when cin is set, a - b - 1 otherwise
  always_comb begin
    unique case (state_r)
      ST_SEND: begin
        sub_a = next_tx_seq_r; sub_b = oldest_unacked_r; sub_cin = 1'b1;
      end
      ST_RX_ACK: begin
        sub_a = rx_ack_r; sub_b = slot_seq_r[idx_r]; sub_cin = 1'b0;
      end
      ST_RX_ADV: begin
        sub_a = oldest_unacked_r; sub_b = next_tx_seq_r; sub_cin = 1'b1;
      end
      ST_TICK_SCAN: begin
        sub_a = now_ms_r; sub_b = slot_time_r[idx_r]; sub_cin = 1'b1;
      end
      default: begin
        sub_a = '0; sub_b = '0; sub_cin = 1'b0;
      end
    endcase
  end

  assign sub_d = sub_a + ~sub_b + {15'd0, sub_cin};

  always_comb begin
    swac_pkg::result_t res;
    logic refused;
    logic qualifies;
    logic exhaust;
    logic [SW-1:0] wslot;

    state_nxt           = state_r;
    idx_nxt             = idx_r;
    role_master_nxt     = role_master_r;
    retry_interval_nxt  = retry_interval_r;
    retry_limit_nxt     = retry_limit_r;
    next_tx_seq_nxt     = next_tx_seq_r;
    oldest_unacked_nxt  = oldest_unacked_r;
    expected_rx_seq_nxt = expected_rx_seq_r;
    previous_rx_seq_nxt = previous_rx_seq_r;
    now_ms_nxt          = now_ms_r;
    slot_busy_nxt       = slot_busy_r;
    type_nxt            = type_r;
    ack_req_nxt         = ack_req_r;
    len_nxt             = len_r;
    rx_seq_nxt          = rx_seq_r;
    rx_ack_nxt          = rx_ack_r;
    space_nxt           = space_r;
    out_valid_nxt       = out_valid_r && !out_tready;
    out_last_nxt        = out_last_r;
    out_res_nxt         = out_res_r;
    hold_valid_nxt      = hold_valid_r;
    hold_res_nxt        = hold_res_r;
    slot_seq_nxt        = slot_seq_r;
    slot_tries_nxt      = slot_tries_r;
    slot_time_nxt       = slot_time_r;
    slot_type_nxt       = slot_type_r;
    slot_len_nxt        = slot_len_r;
    slot_ack_nxt        = slot_ack_r;
    slot_unacked_nxt    = slot_unacked_r;

    res        = '0;
    res.role   = role_w;
    refused    = 1'b0;
    qualifies  = 1'b0;
    exhaust    = 1'b0;
    wslot      = next_tx_seq_r[SW-1:0];

    if (cfg_we) begin
      unique case (swac_pkg::cfg_index_t'(cfg_index))
        swac_pkg::CFG_ROLE_MASTER:    role_master_nxt    = cfg_wdata[0];
        swac_pkg::CFG_RETRY_INTERVAL: retry_interval_nxt = cfg_wdata;
        swac_pkg::CFG_RETRY_LIMIT:    retry_limit_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          type_nxt     = in_type;
          ack_req_nxt  = in_ack_req;
          len_nxt      = (in_len > swac_pkg::MAX_PAYLOAD) ? swac_pkg::MAX_PAYLOAD : in_len;
          rx_seq_nxt   = in_rx_seq;
          rx_ack_nxt   = in_rx_ack;
          space_nxt    = (in_space > swac_pkg::PHY_QUEUE) ? swac_pkg::PHY_QUEUE : in_space;
          idx_nxt      = '0;
          unique case (swac_pkg::action_t'(in_tuser))
            swac_pkg::ACT_SEND: state_nxt = ST_SEND;
            swac_pkg::ACT_RECV: state_nxt = ST_RX_ACK;
            swac_pkg::ACT_TICK: begin
              now_ms_nxt = now_ms_r + 16'd1;
              state_nxt  = ST_TICK_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_SEND: begin
        if (emit_ok) begin
          refused = (ack_req_r && (|sub_d[15:SW])) || (space_r == 5'd0);
          res.kind       = refused ? swac_pkg::KIND_REFUSED : swac_pkg::KIND_SENT;
          res.slot       = (!refused && ack_req_r) ? next_tx_seq_r[SW-1:0] : '0;
          res.seq        = (!refused && ack_req_r) ? next_tx_seq_r : 16'd0;
          res.ack        = expected_rx_seq_r;
          res.unacked    = oldest_unacked_r;
          res.frame_type = type_r;
          res.len        = len_r;
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_res_nxt    = res;
          if (!refused && ack_req_r && (type_r != swac_pkg::TYPE_IDLE)) begin
            slot_busy_nxt[wslot]    = 1'b1;
            slot_seq_nxt[wslot]     = next_tx_seq_r;
            slot_tries_nxt[wslot]   = 8'd1;
            slot_time_nxt[wslot]    = now_ms_r;
            slot_type_nxt[wslot]    = type_r;
            slot_len_nxt[wslot]     = len_r;
            slot_ack_nxt[wslot]     = expected_rx_seq_r;
            slot_unacked_nxt[wslot] = oldest_unacked_r;
            next_tx_seq_nxt         = next_tx_seq_r + 16'd1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_RX_ACK: begin
        if (slot_busy_r[idx_r] && !sub_d[15]) begin
          slot_busy_nxt[idx_r] = 1'b0;
        end
        idx_nxt = idx_r + SW'(1);
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_RX_ADV;
        end
      end

      ST_RX_ADV: begin
        if (sub_d[15] && !slot_busy_r[oldest_unacked_r[SW-1:0]]) begin
          oldest_unacked_nxt = oldest_unacked_r + 16'd1;
        end else begin
          state_nxt = ST_RX_OUT;
        end
      end

      ST_RX_OUT: begin
        if (emit_ok) begin
          if (type_r == swac_pkg::TYPE_IDLE) begin
            res.kind = swac_pkg::KIND_IDLE_RX;
          end else if ((rx_seq_r != previous_rx_seq_r) || (type_r == swac_pkg::TYPE_PONG) ||
                       (type_r == swac_pkg::TYPE_HELLO)) begin
            previous_rx_seq_nxt = rx_seq_r;
            if ((type_r != swac_pkg::TYPE_PONG) && (type_r != swac_pkg::TYPE_HELLO)) begin
              expected_rx_seq_nxt = rx_seq_r + 16'd1;
            end
            res.kind = swac_pkg::KIND_DELIVERED;
          end else begin
            res.kind = swac_pkg::KIND_DUPLICATE;
          end
          res.slot       = '0;
          res.seq        = rx_seq_r;
          res.ack        = expected_rx_seq_nxt;
          res.unacked    = oldest_unacked_r;
          res.frame_type = type_r;
          res.len        = len_r;
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_res_nxt    = res;
          state_nxt      = ST_IDLE;
        end
      end

      ST_TICK_SCAN: begin
        qualifies      = slot_busy_r[idx_r] && !(sub_d < {8'd0, retry_interval_r});
        exhaust        = slot_tries_r[idx_r] >= retry_limit_r;
        res.slot       = idx_r;
        res.seq        = slot_seq_r[idx_r];
        res.ack        = slot_ack_r[idx_r];
        res.unacked    = slot_unacked_r[idx_r];
        res.frame_type = slot_type_r[idx_r];
        res.len        = slot_len_r[idx_r];
        res.kind       = exhaust ? swac_pkg::KIND_EXHAUSTED : swac_pkg::KIND_RETX;
        if (qualifies && !exhaust && (space_r == 5'd0)) begin
          state_nxt = ST_TICK_FLUSH;
        end else if (qualifies) begin
          if (!hold_valid_r || emit_ok) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_res_nxt   = hold_res_r;
            end
            hold_valid_nxt = 1'b1;
            hold_res_nxt   = res;
            if (exhaust) begin
              slot_busy_nxt[idx_r] = 1'b0;
            end else begin
              space_nxt             = space_r - 5'd1;
              slot_tries_nxt[idx_r] = slot_tries_r[idx_r] + 8'd1;
              slot_time_nxt[idx_r]  = now_ms_r;
            end
            idx_nxt = idx_r + SW'(1);
            if (idx_r == LAST_SLOT) begin
              state_nxt = ST_TICK_FLUSH;
            end
          end
        end else begin
          idx_nxt = idx_r + SW'(1);
          if (idx_r == LAST_SLOT) begin
            state_nxt = ST_TICK_FLUSH;
          end
        end
      end

      ST_TICK_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_res_nxt    = hold_res_r;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      idx_r             <= '0;
      role_master_r     <= 1'b1;
      retry_interval_r  <= swac_pkg::RETRY_INTERVAL_RST;
      retry_limit_r     <= swac_pkg::RETRY_LIMIT_RST;
      next_tx_seq_r     <= 16'd1;
      oldest_unacked_r  <= 16'd1;
      expected_rx_seq_r <= 16'd0;
      previous_rx_seq_r <= swac_pkg::PREV_RX_SEQ_RST;
      now_ms_r          <= 16'd0;
      slot_busy_r       <= '0;
      out_valid_r       <= 1'b0;
      hold_valid_r      <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      idx_r             <= idx_nxt;
      role_master_r     <= role_master_nxt;
      retry_interval_r  <= retry_interval_nxt;
      retry_limit_r     <= retry_limit_nxt;
      next_tx_seq_r     <= next_tx_seq_nxt;
      oldest_unacked_r  <= oldest_unacked_nxt;
      expected_rx_seq_r <= expected_rx_seq_nxt;
      previous_rx_seq_r <= previous_rx_seq_nxt;
      now_ms_r          <= now_ms_nxt;
      slot_busy_r       <= slot_busy_nxt;
      out_valid_r       <= out_valid_nxt;
      hold_valid_r      <= hold_valid_nxt;
    end
    type_r         <= type_nxt;
    ack_req_r      <= ack_req_nxt;
    len_r          <= len_nxt;
    rx_seq_r       <= rx_seq_nxt;
    rx_ack_r       <= rx_ack_nxt;
    space_r        <= space_nxt;
    out_last_r     <= out_last_nxt;
    out_res_r      <= out_res_nxt;
    hold_res_r     <= hold_res_nxt;
    slot_seq_r     <= slot_seq_nxt;
    slot_tries_r   <= slot_tries_nxt;
    slot_time_r    <= slot_time_nxt;
    slot_type_r    <= slot_type_nxt;
    slot_len_r     <= slot_len_nxt;
    slot_ack_r     <= slot_ack_nxt;
    slot_unacked_r <= slot_unacked_nxt;
  end

  `SWAC_ASSERT_IMP(a_idle_no_hold, clk, rst_n, in_tready, !hold_valid_r,
                   "held result while idle")
  `SWAC_ASSERT_NXT(a_busy_after_accept, clk, rst_n,
                   in_tvalid && in_tready &&
                   (in_tuser == swac_pkg::ACT_SEND || in_tuser == swac_pkg::ACT_RECV),
                   !in_tready, "ready right after send or receive")
  `SWAC_ASSERT_IMP(a_inflight_bound, clk, rst_n, 1'b1,
                   16'(next_tx_seq_r - oldest_unacked_r) <= 16'(swac_pkg::WINDOW),
                   "frames in flight exceed window")
  `SWAC_ASSERT_IMP(a_hold_in_tick, clk, rst_n, hold_valid_r,
                   state_r == ST_TICK_SCAN || state_r == ST_TICK_FLUSH,
                   "held result outside tick scan")

endmodule

[bench/sliding_window_arq_controller_unit_tb.sv]
`timescale 1ns / 100ps

module sliding_window_arq_controller_unit_tb;

  typedef struct packed {
    swac_pkg::action_t act;
    logic [7:0]        ftype;
    logic              ack_req;
    logic [7:0]        plen;
    logic [15:0]       rseq;
    logic [15:0]       rack;
    logic [4:0]        space;
  } frame_req_t;

  typedef struct packed {
    swac_pkg::kind_t kind;
    logic [3:0]      slot;
    logic [15:0]     seq;
    logic [15:0]     ack;
    logic [15:0]     unacked;
    logic [7:0]      ftype;
    logic [7:0]      len;
    logic [1:0]      role;
    logic            last;
  } header_t;

  typedef struct packed {
    frame_req_t req;
    logic       typed;
    header_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // frame_type[7:0], ack_req[8], payload_len[16:9], rx_seq[32:17],
  // rx_ack[48:33], phy_space[53:49], zero fill[55:54]
  logic [55:0] in_tdata;
  // action[1:0]
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // slot[3:0], seq_out[19:4], ack_out[35:20], unacked_out[51:36],
  // type_out[59:52], len_out[67:60], role_code[69:68], zero fill[71:70]
  logic [71:0] out_tdata;
  // kind[2:0]
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  sliding_window_arq_controller_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ARQ state mirror
  logic        arq_role;
  logic [7:0]  arq_interval;
  logic [7:0]  arq_limit;
  logic [15:0] tx_next;
  logic [15:0] tx_oldest;
  logic [15:0] rx_expect;
  logic [15:0] rx_prev;
  logic [15:0] clock_ms;
  logic        slot_armed [swac_pkg::WINDOW];
  logic [15:0] slot_seqno [swac_pkg::WINDOW];
  logic [7:0]  slot_sends [swac_pkg::WINDOW];
  logic [15:0] slot_stamp [swac_pkg::WINDOW];
  logic [7:0]  slot_ftype [swac_pkg::WINDOW];
  logic [7:0]  slot_plen [swac_pkg::WINDOW];
  logic [15:0] slot_ackno [swac_pkg::WINDOW];
  logic [15:0] slot_oldest [swac_pkg::WINDOW];

  header_t pending_headers [$];
  int      fault_count;
  bit      no_idle;

  stim_row_t directed_rows [20] = '{
    '{'{swac_pkg::ACT_SEND, 8'h10, 1'b0, 8'hFF, 16'h0000, 16'h0000, 5'd16}, 1'b1,
      '{swac_pkg::KIND_SENT, 4'd0, 16'd0, 16'd0, 16'd1, 8'h10, 8'd119,
        swac_pkg::ROLE_MASTER, 1'b1}},
    '{'{swac_pkg::ACT_SEND, 8'hFF, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 5'd0}, 1'b1,
      '{swac_pkg::KIND_REFUSED, 4'd0, 16'd0, 16'd0, 16'd1, 8'hFF, 8'd0,
        swac_pkg::ROLE_MASTER, 1'b1}},
    '{'{swac_pkg::ACT_SEND, 8'h00, 1'b1, 8'd5, 16'h0000, 16'h0000, 5'd31}, 1'b1,
      '{swac_pkg::KIND_SENT, 4'd1, 16'd1, 16'd0, 16'd1, 8'h00, 8'd5,
        swac_pkg::ROLE_MASTER, 1'b1}},
    '{'{swac_pkg::ACT_SEND, 8'h22, 1'b1, 8'd119, 16'h0000, 16'h0000, 5'd1}, 1'b1,
      '{swac_pkg::KIND_SENT, 4'd1, 16'd1, 16'd0, 16'd1, 8'h22, 8'd119,
        swac_pkg::ROLE_MASTER, 1'b1}},
    '{'{swac_pkg::ACT_RECV, 8'h30, 1'b0, 8'd7, 16'hFFFF, 16'h0000, 5'd0}, 1'b1,
      '{swac_pkg::KIND_DUPLICATE, 4'd0, 16'hFFFF, 16'd0, 16'd1, 8'h30, 8'd7,
        swac_pkg::ROLE_MASTER, 1'b1}},
    '{'{swac_pkg::ACT_RECV, 8'h30, 1'b1, 8'd200, 16'h0000, 16'h0000, 5'd16}, 1'b0, '0},
    '{'{swac_pkg::ACT_RECV, swac_pkg::TYPE_HELLO, 1'b0, 8'd0, 16'h0000, 16'h0001, 5'd3},
      1'b0, '0},
    '{'{swac_pkg::ACT_RECV, swac_pkg::TYPE_PONG, 1'b0, 8'hFF, 16'h0005, 16'h0002, 5'd31},
      1'b0, '0},
    '{'{swac_pkg::ACT_RECV, swac_pkg::TYPE_IDLE, 1'b1, 8'd9, 16'h0009, 16'h0002, 5'd0},
      1'b0, '0},
    '{'{swac_pkg::ACT_RECV, 8'h30, 1'b0, 8'd1, 16'h0005, 16'h0002, 5'd1}, 1'b0, '0},
    '{'{swac_pkg::ACT_TICK, 8'h00, 1'b0, 8'd0, 16'h0000, 16'h0000, 5'd16}, 1'b0, '0},
    '{'{swac_pkg::ACT_NONE, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31}, 1'b0, '0},
    '{'{swac_pkg::ACT_SEND, 8'h41, 1'b1, 8'd1, 16'h1234, 16'h8000, 5'd16}, 1'b0, '0},
    '{'{swac_pkg::ACT_SEND, 8'h80, 1'b1, 8'd118, 16'h0000, 16'h0000, 5'd31}, 1'b0, '0},
    '{'{swac_pkg::ACT_SEND, 8'hFE, 1'b1, 8'd120, 16'h0000, 16'h0000, 5'd2}, 1'b0, '0},
    '{'{swac_pkg::ACT_TICK, 8'h55, 1'b1, 8'hAA, 16'h5555, 16'hAAAA, 5'd0}, 1'b0, '0},
    '{'{swac_pkg::ACT_RECV, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd16}, 1'b0, '0},
    '{'{swac_pkg::ACT_SEND, swac_pkg::TYPE_HELLO, 1'b1, 8'hFF, 16'h0000, 16'h0000, 5'd16},
      1'b0, '0},
    '{'{swac_pkg::ACT_TICK, 8'h00, 1'b0, 8'd0, 16'h0000, 16'h0000, 5'd31}, 1'b0, '0},
    '{'{swac_pkg::ACT_SEND, swac_pkg::TYPE_IDLE, 1'b0, 8'd0, 16'h0000, 16'h0000, 5'd1},
      1'b0, '0}
  };

  function automatic logic seq_precedes(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

  function automatic string describe(input header_t r);
    return $sformatf({"kind=%0d slot=%0d seq=%h ack=%h unacked=%h type=%h len=%0d ",
                      "role=%0d last=%0b"},
                     r.kind, r.slot, r.seq, r.ack, r.unacked, r.ftype, r.len, r.role,
                     r.last);
  endfunction

  task automatic flag_mismatch(input string note, input header_t want, input header_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected %s", note, describe(want));
      $display("%s: actual   %s", note, describe(got));
    end
  endtask

  // Forecast the headers of one item, then drive it until accepted.
  task automatic present_item(input frame_req_t it, input logic typed, input header_t want);
    int          gap;
    int          i;
    logic [4:0]  room;
    logic [7:0]  plen;
    logic [15:0] seq;
    logic [15:0] inflight;
    logic [15:0] age;
    logic [3:0]  sl;
    header_t     r;
    header_t     made [$];
    gap = 0;
    while (!no_idle && $urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    room = (it.space > swac_pkg::PHY_QUEUE) ? swac_pkg::PHY_QUEUE : it.space;
    plen = (it.plen > swac_pkg::MAX_PAYLOAD) ? swac_pkg::MAX_PAYLOAD : it.plen;
    r = '0;
    r.role = arq_role ? swac_pkg::ROLE_MASTER : swac_pkg::ROLE_SLAVE;
    r.ftype = it.ftype;
    r.len = plen;
    case (it.act)
      swac_pkg::ACT_SEND: begin
        inflight = tx_next - tx_oldest;
        r.ack = rx_expect;
        r.unacked = tx_oldest;
        if ((it.ack_req && inflight >= swac_pkg::WINDOW) || room == 5'd0) begin
          r.kind = swac_pkg::KIND_REFUSED;
        end else begin
          seq = it.ack_req ? tx_next : 16'd0;
          sl = seq[swac_pkg::SLOT_W-1:0];
          r.kind = swac_pkg::KIND_SENT;
          r.slot = sl;
          r.seq = seq;
          if (it.ack_req && it.ftype != swac_pkg::TYPE_IDLE) begin
            slot_armed[sl] = 1'b1;
            slot_seqno[sl] = seq;
            slot_sends[sl] = 8'd1;
            slot_stamp[sl] = clock_ms;
            slot_ftype[sl] = it.ftype;
            slot_plen[sl] = plen;
            slot_ackno[sl] = rx_expect;
            slot_oldest[sl] = tx_oldest;
            tx_next = tx_next + 16'd1;
          end
        end
        made.push_back(r);
      end
      swac_pkg::ACT_RECV: begin
        for (i = 0; i < swac_pkg::WINDOW; i++) begin
          if (slot_armed[i] && !seq_precedes(it.rack, slot_seqno[i] + 16'd1))
            slot_armed[i] = 1'b0;
        end
        while (seq_precedes(tx_oldest, tx_next) &&
               !slot_armed[tx_oldest[swac_pkg::SLOT_W-1:0]])
          tx_oldest = tx_oldest + 16'd1;
        if (it.ftype == swac_pkg::TYPE_IDLE) begin
          r.kind = swac_pkg::KIND_IDLE_RX;
        end else if (it.rseq != rx_prev || it.ftype == swac_pkg::TYPE_PONG ||
                     it.ftype == swac_pkg::TYPE_HELLO) begin
          rx_prev = it.rseq;
          if (it.ftype != swac_pkg::TYPE_PONG && it.ftype != swac_pkg::TYPE_HELLO)
            rx_expect = it.rseq + 16'd1;
          r.kind = swac_pkg::KIND_DELIVERED;
        end else begin
          r.kind = swac_pkg::KIND_DUPLICATE;
        end
        r.seq = it.rseq;
        r.ack = rx_expect;
        r.unacked = tx_oldest;
        made.push_back(r);
      end
      swac_pkg::ACT_TICK: begin
        clock_ms = clock_ms + 16'd1;
        for (i = 0; i < swac_pkg::WINDOW && made.size() < 16; i++) begin
          if (!slot_armed[i]) continue;
          age = clock_ms - slot_stamp[i];
          if (age < arq_interval) continue;
          r.slot = i[3:0];
          r.seq = slot_seqno[i];
          r.ack = slot_ackno[i];
          r.unacked = slot_oldest[i];
          r.ftype = slot_ftype[i];
          r.len = slot_plen[i];
          if (slot_sends[i] >= arq_limit) begin
            slot_armed[i] = 1'b0;
            r.kind = swac_pkg::KIND_EXHAUSTED;
            made.push_back(r);
            continue;
          end
          if (room == 5'd0) break;
          room = room - 5'd1;
          slot_sends[i] = slot_sends[i] + 8'd1;
          slot_stamp[i] = clock_ms;
          r.kind = swac_pkg::KIND_RETX;
          made.push_back(r);
        end
      end
      default: begin
      end
    endcase
    if (made.size() > 0) begin
      r = made.pop_back();
      r.last = 1'b1;
      made.push_back(r);
    end
    if (typed) pending_headers.push_back(want);
    else while (made.size() > 0) pending_headers.push_back(made.pop_front());
    in_tvalid <= 1'b1;
    in_tuser <= it.act;
    in_tdata <= {2'b00, it.space, it.rack, it.rseq, it.plen, it.ack_req, it.ftype};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("sliding_window_arq_controller_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    header_t got;
    header_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = swac_pkg::kind_t'(out_tuser);
      got.slot = out_tdata[3:0];
      got.seq = out_tdata[19:4];
      got.ack = out_tdata[35:20];
      got.unacked = out_tdata[51:36];
      got.ftype = out_tdata[59:52];
      got.len = out_tdata[67:60];
      got.role = out_tdata[69:68];
      got.last = out_tlast;
      if (pending_headers.size() == 0) begin
        flag_mismatch("unexpected header", '0, got);
      end else begin
        want = pending_headers.pop_front();
        if (got !== want) flag_mismatch("header mismatch", want, got);
      end
    end
  end

  initial begin
    frame_req_t  it;
    int          ph;
    int          n;
    int          d;
    int          pick;
    logic [15:0] span;
    logic        role_pick;
    logic [7:0]  ivl;
    logic [7:0]  lim;
    logic [6:0]  filler;
    fault_count = 0;
    no_idle = 1'b0;
    arq_role = 1'b1;
    arq_interval = swac_pkg::RETRY_INTERVAL_RST;
    arq_limit = swac_pkg::RETRY_LIMIT_RST;
    tx_next = 16'd1;
    tx_oldest = 16'd1;
    rx_expect = 16'd0;
    rx_prev = swac_pkg::PREV_RX_SEQ_RST;
    clock_ms = 16'd0;
    for (d = 0; d < swac_pkg::WINDOW; d++) slot_armed[d] = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= swac_pkg::ACT_NONE;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= swac_pkg::CFG_ROLE_MASTER;
    cfg_wdata <= 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (d = 0; d < $size(directed_rows); d++)
      present_item(directed_rows[d].req, directed_rows[d].typed, directed_rows[d].want);

    for (ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin role_pick = 1'b0; ivl = 8'd1; lim = 8'd1; end
        1: begin role_pick = 1'b1; ivl = 8'd255; lim = 8'd255; end
        2: begin role_pick = 1'b0; ivl = 8'd2; lim = 8'd3; end
        3: begin role_pick = 1'b1; ivl = 8'd6; lim = 8'd12; end
        4: begin
          role_pick = 1'($urandom_range(0, 1));
          ivl = 8'($urandom_range(1, 9));
          lim = 8'($urandom_range(1, 20));
        end
        default: begin role_pick = 1'b1; ivl = 8'd1; lim = 8'd255; end
      endcase
      filler = 7'($urandom_range(0, 127));
      cfg_we <= 1'b1;
      cfg_index <= swac_pkg::CFG_ROLE_MASTER;
      cfg_wdata <= {filler, role_pick};
      @(posedge clk);
      cfg_index <= swac_pkg::CFG_RETRY_INTERVAL;
      cfg_wdata <= ivl;
      @(posedge clk);
      cfg_index <= swac_pkg::CFG_RETRY_LIMIT;
      cfg_wdata <= lim;
      @(posedge clk);
      cfg_we <= 1'b0;
      arq_role = role_pick;
      arq_interval = ivl;
      arq_limit = lim;
      no_idle = (ph == 3);

      for (n = 0; n < 56; n++) begin
        it = '0;
        it.ftype = 8'($urandom_range(1, 255));
        it.ack_req = 1'b1;
        it.plen = 8'($urandom_range(0, 255));
        it.rseq = 16'($urandom);
        it.rack = 16'($urandom);
        it.space = 5'($urandom_range(1, 16));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          it.act = swac_pkg::action_t'($urandom_range(0, 3));
          it.ftype = 8'($urandom_range(0, 255));
          it.ack_req = 1'($urandom_range(0, 1));
          it.space = 5'($urandom_range(0, 31));
        end else if (pick < 50) begin
          it.act = swac_pkg::ACT_SEND;
          if ($urandom_range(0, 99) < 15) it.ack_req = 1'b0;
          if ($urandom_range(0, 99) < 10) it.ftype = swac_pkg::TYPE_IDLE;
          case ($urandom_range(0, 9))
            0: it.space = 5'd0;
            1: it.space = 5'($urandom_range(17, 31));
            default: begin
            end
          endcase
        end else if (pick < 72) begin
          it.act = swac_pkg::ACT_RECV;
          case ($urandom_range(0, 9))
            0: it.ftype = swac_pkg::TYPE_IDLE;
            1: it.ftype = swac_pkg::TYPE_HELLO;
            2: it.ftype = swac_pkg::TYPE_PONG;
            default: begin
            end
          endcase
          case ($urandom_range(0, 3))
            0, 1: it.rseq = rx_expect;
            2: it.rseq = rx_prev;
            default: begin
            end
          endcase
          span = tx_next - tx_oldest;
          case ($urandom_range(0, 4))
            0, 1: it.rack = tx_oldest;
            2, 3: it.rack = tx_oldest + 16'($urandom_range(0, span));
            default: begin
            end
          endcase
        end else begin
          it.act = swac_pkg::ACT_TICK;
          if ($urandom_range(0, 9) == 0) it.space = 5'($urandom_range(17, 31));
          else it.space = 5'($urandom_range(0, 16));
        end
        present_item(it, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_results();
    if (fault_count == 0 && pending_headers.size() == 0) begin
      $display("sliding_window_arq_controller_unit verification clean");
    end else begin
      $display("sliding_window_arq_controller_unit verification failed");
    end
    $finish;
  end

endmodule
